// ===== src/ternary_weight_quantize_pack_macros.svh =====
// Assertion macros for the ternary weight quantizer and packer.
// Each expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef TERNARY_WEIGHT_QUANTIZE_PACK_MACROS_SVH
`define TERNARY_WEIGHT_QUANTIZE_PACK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/twq_pkg.sv =====
// Shared types, widths and codes for the ternary weight quantizer and packer.
// No dependencies; every other file but the macros header imports this package.
`default_nettype none

package twq_pkg;

  localparam int WEIGHT_BITS    = 16;
  localparam int COUNT_BITS     = 24;
  localparam int CODES_PER_WORD = 16;

  localparam int SUM_BITS   = 40;
  localparam int DATA_BITS  = 40;
  localparam int TOTAL_BITS = 24;
  localparam int COL_BITS   = 16;
  localparam int CODE_BITS  = 2;
  localparam int WORD_BITS  = CODE_BITS * CODES_PER_WORD;
  localparam int SLOT_BITS  = $clog2(CODES_PER_WORD);
  localparam int PROD_BITS  = WEIGHT_BITS + COUNT_BITS + 1;
  localparam int CMP_BITS   = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;

  localparam logic [COL_BITS-1:0]   ROW_LENGTH_RESET = COL_BITS'(16);
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_QUANTIZE   = 1'b1;

  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  localparam logic [CODE_BITS-1:0] CODE_ZERO = 2'b00;
  localparam logic [CODE_BITS-1:0] CODE_POS  = 2'b01;
  localparam logic [CODE_BITS-1:0] CODE_NEG  = 2'b11;

  typedef struct packed {
    logic                          operation;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          last_of_pass;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [DATA_BITS-1:0]  data;
    logic [TOTAL_BITS-1:0] weight_total;
    logic                  overflow;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/twq_if.sv =====
// Valid/ready stream interfaces for weight words in and result words out.
// Depends on twq_pkg for the payload structs.
`default_nettype none

interface twq_in_if import twq_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface twq_out_if import twq_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== src/ternary_weight_quantize_pack.sv =====
// Channel     Dir  Payload                                    Handshake
// weight_ch   in   operation, weight, last_of_pass            valid/ready
// result_ch   out  kind, data, weight_total, overflow         valid/ready
// cfg         in   row_length (16 bit)                        cfg_wr_en
//
// One word per cycle sustained while results are taken; a word passes the input register,
// then the multiply-compare and packing path into the result register.
// rst is synchronous: it clears the totals, packing state and both stages and
// sets row_length to 16.
// A waiting result holds the result register; the input register then holds,
// and weight_ch.ready falls once both are full.
`default_nettype none
`include "ternary_weight_quantize_pack_macros.svh"

module ternary_weight_quantize_pack import twq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [COL_BITS-1:0] cfg_wr_data,
  twq_in_if.sink                   weight_ch,
  twq_out_if.source                result_ch
);

  logic [COL_BITS-1:0]   row_length;

  logic                  s1_valid;
  in_item_t              s1_item;
  logic                  out_free;
  logic                  s1_go;

  logic [SUM_BITS-1:0]   magnitude_sum,    magnitude_sum_next;
  logic [COUNT_BITS-1:0] item_count,       item_count_next;
  logic                  count_saturated,  count_saturated_next;
  logic                  totals_closed,    totals_closed_next;
  logic [COL_BITS-1:0]   column_position,  column_position_next;
  logic [SLOT_BITS-1:0]  code_slot,        code_slot_next;
  logic [WORD_BITS-1:0]  word_in_progress, word_in_progress_next;

  logic                  res_valid;
  out_item_t             res_item,         res_item_next;
  logic                  emit;

  logic [WEIGHT_BITS-1:0] magnitude;
  logic [CODE_BITS-1:0]   code;

  logic [SUM_BITS-1:0]   base_sum;
  logic [COUNT_BITS-1:0] base_count;
  logic                  base_saturated;
  logic [SUM_BITS:0]     sum_wide;
  logic [WORD_BITS-1:0]  word_filled;
  logic [COL_BITS-1:0]   column_step;
  logic                  row_end;
  logic                  word_full;

  twq_ternary u_ternary (
    .weight        (s1_item.weight),
    .magnitude_sum (magnitude_sum),
    .item_count    (item_count),
    .magnitude     (magnitude),
    .code          (code)
  );

  assign out_free        = !res_valid || result_ch.ready;
  assign s1_go           = s1_valid && out_free;
  assign weight_ch.ready = !s1_valid || out_free;
  assign result_ch.valid = res_valid;
  assign result_ch.item  = res_item;

  // A new accumulate pass starts from clear totals once the last one was returned.
  assign base_sum       = totals_closed ? '0 : magnitude_sum;
  assign base_count     = totals_closed ? '0 : item_count;
  assign base_saturated = totals_closed ? 1'b0 : count_saturated;
  assign sum_wide       = {1'b0, base_sum} + (SUM_BITS+1)'(magnitude);

  assign word_filled = word_in_progress | (WORD_BITS'(code) << {code_slot, 1'b0});
  assign column_step = column_position + 1'b1;
  assign row_end     = column_step == row_length;
  assign word_full   = code_slot == SLOT_BITS'(CODES_PER_WORD - 1);

  always_comb begin
    magnitude_sum_next    = magnitude_sum;
    item_count_next       = item_count;
    count_saturated_next  = count_saturated;
    totals_closed_next    = totals_closed;
    column_position_next  = column_position;
    code_slot_next        = code_slot;
    word_in_progress_next = word_in_progress;
    emit                  = 1'b0;
    res_item_next         = '0;

    if (s1_item.operation == OP_ACCUMULATE) begin
      // drop any partial word
      column_position_next  = '0;
      code_slot_next        = '0;
      word_in_progress_next = '0;
      magnitude_sum_next    = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
      if (base_count == COUNT_MAX) begin
        item_count_next      = COUNT_MAX;
        count_saturated_next = 1'b1;
      end else begin
        item_count_next      = base_count + 1'b1;
        count_saturated_next = base_saturated;
      end
      totals_closed_next = s1_item.last_of_pass;
      if (s1_item.last_of_pass) begin
        emit                       = 1'b1;
        res_item_next.kind         = KIND_TOTAL;
        res_item_next.data         = DATA_BITS'(magnitude_sum_next);
        res_item_next.weight_total = TOTAL_BITS'(item_count_next);
        res_item_next.overflow     = count_saturated_next;
      end
    end else begin
      column_position_next = (row_end || s1_item.last_of_pass) ? '0 : column_step;
      if (row_end || s1_item.last_of_pass || word_full) begin
        emit                  = 1'b1;
        res_item_next.kind    = KIND_WORD;
        res_item_next.data    = DATA_BITS'(word_filled);
        code_slot_next        = '0;
        word_in_progress_next = '0;
      end else begin
        code_slot_next        = code_slot + 1'b1;
        word_in_progress_next = word_filled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length       <= ROW_LENGTH_RESET;
      s1_valid         <= 1'b0;
      res_valid        <= 1'b0;
      magnitude_sum    <= '0;
      item_count       <= '0;
      count_saturated  <= 1'b0;
      totals_closed    <= 1'b0;
      column_position  <= '0;
      code_slot        <= '0;
      word_in_progress <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_length <= cfg_wr_data;
      end
      if (weight_ch.ready) begin
        s1_valid <= weight_ch.valid;
        s1_item  <= weight_ch.item;
      end
      if (s1_go) begin
        magnitude_sum    <= magnitude_sum_next;
        item_count       <= item_count_next;
        count_saturated  <= count_saturated_next;
        totals_closed    <= totals_closed_next;
        column_position  <= column_position_next;
        code_slot        <= code_slot_next;
        word_in_progress <= word_in_progress_next;
        res_valid        <= emit;
        if (emit) begin
          res_item <= res_item_next;
        end
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `TWQ_ASSERT_IMPLY(a_word_no_totals, result_ch.valid && result_ch.item.kind == KIND_WORD, result_ch.item.weight_total == '0 && !result_ch.item.overflow, "code word carries totals")
  `TWQ_ASSERT_NEXT(a_accumulate_clears_pack, s1_go && s1_item.operation == OP_ACCUMULATE, code_slot == '0 && word_in_progress == '0 && column_position == '0, "packing state left after accumulate")
  `TWQ_ASSERT_IMPLY(a_saturated_count_held, count_saturated, item_count == COUNT_MAX, "saturation flag without full count")

endmodule

`default_nettype wire

// ===== src/twq_ternary.sv =====
// Ternary decision for one weight: magnitude, sign and the 2-bit code.
// Depends on twq_pkg for widths and code values.
`default_nettype none

module twq_ternary import twq_pkg::*; (
  input  wire logic signed [WEIGHT_BITS-1:0] weight,
  input  wire logic [SUM_BITS-1:0]           magnitude_sum,
  input  wire logic [COUNT_BITS-1:0]         item_count,
  output logic [WEIGHT_BITS-1:0]             magnitude,
  output logic [CODE_BITS-1:0]               code
);

  logic [WEIGHT_BITS-1:0]             weight_u;
  logic                               negative;
  logic [WEIGHT_BITS+COUNT_BITS-1:0]  product;
  logic [CMP_BITS-1:0]                scaled;
  logic                               reaches_mean;

  assign weight_u = weight;
  assign negative = weight[WEIGHT_BITS-1];

  // The most negative weight wraps to 2^(WEIGHT_BITS-1), which is its true magnitude.
  assign magnitude = negative ? (~weight_u + 1'b1) : weight_u;

  assign product = (WEIGHT_BITS+COUNT_BITS)'(magnitude) * (WEIGHT_BITS+COUNT_BITS)'(item_count);

  // 2*|w|*count >= sum stands in for |w| >= mean/2 without a divide
  assign scaled       = CMP_BITS'({product, 1'b0});
  assign reaches_mean = scaled >= CMP_BITS'(magnitude_sum);

  always_comb begin
    if (magnitude != '0 && reaches_mean) begin
      code = negative ? CODE_NEG : CODE_POS;
    end else begin
      code = CODE_ZERO;
    end
  end

endmodule

`default_nettype wire
